// ===== design/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg: shared constants and types of the bit stream pack/unpack core
// Store geometry, cursor widths, request kinds and the bank write record.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int STORE_WORDS = 256;
    localparam int WORD_W      = 32;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int NUM_BANKS   = 2;
    localparam int BANK_DEPTH  = STORE_WORDS / NUM_BANKS;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    localparam int CAP_W       = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(400);

    // cursor must hold the largest bit limit, both of the store and of the register
    localparam int STORE_BITS_W = $clog2(STORE_WORDS * WORD_W) + 1;
    localparam int POS_W        = (STORE_BITS_W > CAP_W + 3) ? STORE_BITS_W : CAP_W + 3;
    localparam logic [POS_W-1:0] LIMIT_MAX = POS_W'(STORE_WORDS * WORD_W);

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_W);

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } bank_wr_t;

endpackage

// ===== design/bit_stream_pack_unpack_core.sv =====
// ----------------------------------------------------------------------------
// bit_stream_pack_unpack_core: bit field packer and unpacker over a word store
// Writes and reads fields of 0 to 32 bits at a running bit cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the kind (restart,
//   write, read), tdata the write field and the bit count. Every request
//   yields one result on m_axis: read field, echoed count, overflow flag.
//   Stream bit p lives in bit p mod 32 of store word p/32. Bits at or past
//   capacity_bytes*8 are dropped on write, read as zero, set the sticky
//   overflow flag and do not advance the cursor.
//   The cursor and flag are updated when a request is accepted; the store
//   (two word-interleaved banks) is read in that same edge, then merged
//   and written back from the merge stage, with the last write forwarded
//   to the next read; results go through the merge and result registers.
//   Throughput is one request per cycle while m_axis accepts; a field
//   touches at most two store words, one per bank, so one read and one
//   write port per bank suffice. When m_axis stalls, the result register
//   and the merge stage hold; s_axis_tready drops once that stage is full.
//   Reset clears cursor and flag and sets capacity to 400 bytes; store
//   contents stay undefined until written. Write cfg_data only while idle.
// ----------------------------------------------------------------------------
module bit_stream_pack_unpack_core
    import bsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration: capacity_bytes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data,
    // requests
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // [31:0] write_value, [37:32] bit_count
    input  logic [1:0]        s_axis_tuser,   // [1:0] kind
    // results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata    // [31:0] read_value, [37:32] bits_done,
                                              // [38] overflow
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [WORD_W-1:0]  wval;
        logic [CNT_W-1:0]   k;        // bits that fit below the limit
        logic [CNT_W-1:0]   done;     // echoed count
        logic               ovf;      // flag after this request
        logic [4:0]         off;      // bit offset in the first word
        logic               lo_odd;   // first word lives in the odd bank
        logic [BANK_AW-1:0] even_addr;
        logic [BANK_AW-1:0] odd_addr;
    } stage_t;

    logic [CAP_W-1:0]  cap_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ovf_reg, ovf_next;
    logic              s1_valid_reg;
    stage_t            s1_reg, s1_next;
    logic              out_valid_reg;
    logic [39:0]       out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // accept: cursor, limit and bank addresses
    // ------------------------------------------------------------------
    logic              s1_move;
    logic              in_acc;
    logic [1:0]        in_kind;
    logic [CNT_W-1:0]  in_cnt;
    logic [CNT_W-1:0]  cnt_sat;
    logic [POS_W-1:0]  cap_bits;
    logic [POS_W-1:0]  lim_bits;
    logic [POS_W-1:0]  avail;
    logic [CNT_W-1:0]  k_fit;
    logic              is_rw;
    logic [WORD_AW-1:0] w_lo;
    logic [WORD_AW-1:0] w_hi;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_cnt        = s_axis_tdata[37:32];
    assign is_rw         = (in_kind == KIND_WRITE) || (in_kind == KIND_READ);

    always_comb
    begin
        cnt_sat  = (in_cnt > CNT_MAX) ? CNT_MAX : in_cnt;
        cap_bits = POS_W'({cap_reg, 3'b000});
        lim_bits = (cap_bits > LIMIT_MAX) ? LIMIT_MAX : cap_bits;
        avail    = (pos_reg < lim_bits) ? (lim_bits - pos_reg) : '0;
        k_fit    = (avail < POS_W'(cnt_sat)) ? avail[CNT_W-1:0] : cnt_sat;

        w_lo = pos_reg[WORD_AW+4:5];
        w_hi = w_lo + WORD_AW'(1);
        // odd bank: first word if odd, else the following (odd) word; same row
        rd_addr[1] = w_lo[WORD_AW-1:1];
        rd_addr[0] = w_lo[0] ? w_hi[WORD_AW-1:1] : w_lo[WORD_AW-1:1];

        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (in_kind == KIND_RESTART)
        begin
            pos_next = '0;
            ovf_next = 1'b0;
        end
        else if (is_rw)
        begin
            pos_next = pos_reg + POS_W'(k_fit);
            ovf_next = ovf_reg | (k_fit != cnt_sat);
        end

        s1_next.kind      = in_kind;
        s1_next.wval      = s_axis_tdata[31:0];
        s1_next.k         = is_rw ? k_fit : '0;
        s1_next.done      = is_rw ? cnt_sat : '0;
        s1_next.ovf       = ovf_next;
        s1_next.off       = pos_reg[4:0];
        s1_next.lo_odd    = w_lo[0];
        s1_next.even_addr = rd_addr[0];
        s1_next.odd_addr  = rd_addr[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                pos_reg <= pos_next;
                ovf_reg <= ovf_next;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // store
    // ------------------------------------------------------------------
    bank_wr_t [NUM_BANKS-1:0]          bank_wr;
    logic [NUM_BANKS-1:0][WORD_W-1:0]  bank_rd;

    bsp_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .wr      (bank_wr),
        .rd_data (bank_rd)
    );

    // ------------------------------------------------------------------
    // merge: read-modify-write of the two touched words
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]    lo_word;
    logic [WORD_W-1:0]    hi_word;
    logic [2*WORD_W-1:0]  pair;
    logic [2*WORD_W-1:0]  fmask;
    logic [2*WORD_W-1:0]  fdata;
    logic [2*WORD_W-1:0]  merged;
    logic [2*WORD_W-1:0]  shifted;
    logic [WORD_W-1:0]    kmask;
    logic [WORD_W-1:0]    rval;
    logic                 hi_touch;
    logic                 lo_we;
    logic                 hi_we;

    always_comb
    begin
        lo_word  = s1_reg.lo_odd ? bank_rd[1] : bank_rd[0];
        hi_word  = s1_reg.lo_odd ? bank_rd[0] : bank_rd[1];
        pair     = {hi_word, lo_word};
        kmask    = s1_reg.k[5] ? '1 : ((WORD_W'(1) << s1_reg.k[4:0]) - WORD_W'(1));
        fmask    = {{WORD_W{1'b0}}, kmask} << s1_reg.off;
        fdata    = {{WORD_W{1'b0}}, s1_reg.wval & kmask} << s1_reg.off;
        merged   = (pair & ~fmask) | fdata;
        shifted  = pair >> s1_reg.off;
        rval     = (s1_reg.kind == KIND_READ) ? (shifted[WORD_W-1:0] & kmask) : '0;
        hi_touch = (7'(s1_reg.off) + 7'(s1_reg.k)) > 7'(WORD_W);

        lo_we = s1_move && (s1_reg.kind == KIND_WRITE) && (s1_reg.k != '0);
        hi_we = s1_move && (s1_reg.kind == KIND_WRITE) && hi_touch;

        bank_wr[0].en   = s1_reg.lo_odd ? hi_we : lo_we;
        bank_wr[0].addr = s1_reg.even_addr;
        bank_wr[0].data = s1_reg.lo_odd ? merged[2*WORD_W-1:WORD_W] : merged[WORD_W-1:0];
        bank_wr[1].en   = s1_reg.lo_odd ? lo_we : hi_we;
        bank_wr[1].addr = s1_reg.odd_addr;
        bank_wr[1].data = s1_reg.lo_odd ? merged[WORD_W-1:0] : merged[2*WORD_W-1:WORD_W];

        out_data_next = {1'b0, s1_reg.ovf, s1_reg.done, rval};
    end

    // ------------------------------------------------------------------
    // result register: hold while the receiver stalls
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LIMIT_MAX)
        else $error("cursor beyond store size");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_kind != KIND_RESTART) && ovf_reg) |=> ovf_reg)
        else $error("overflow flag cleared without restart");

    a_fit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_reg.k <= s1_reg.done))
        else $error("more bits placed than requested");

    a_hi_needs_lo: assert property (@(posedge clk) disable iff (!rst_n)
        hi_we |-> lo_we)
        else $error("second word written without the first");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg && $stable(s1_reg))
        else $error("merge stage lost a request under stall");

endmodule

// ===== design/bsp_store.sv =====
// ----------------------------------------------------------------------------
// bsp_store: two-bank word store with write-to-read forwarding
// Even and odd words sit in separate banks so that a field spanning two
// words reads both and writes both together. Read data is registered.
// ----------------------------------------------------------------------------
module bsp_store
    import bsp_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [NUM_BANKS-1:0][BANK_AW-1:0]   rd_addr,
    input  bank_wr_t [NUM_BANKS-1:0]            wr,
    output logic [NUM_BANKS-1:0][WORD_W-1:0]    rd_data
);

    logic [WORD_W-1:0]                    bank_mem [NUM_BANKS][BANK_DEPTH];
    logic [NUM_BANKS-1:0][WORD_W-1:0]     rd_q_reg;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]    rd_addr_reg;
    logic [NUM_BANKS-1:0]                 fwd_valid_reg;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]    fwd_addr_reg;
    logic [NUM_BANKS-1:0][WORD_W-1:0]     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (wr[b].en)
            begin
                bank_mem[b][wr[b].addr] <= wr[b].data;
                fwd_addr_reg[b]         <= wr[b].addr;
                fwd_data_reg[b]         <= wr[b].data;
            end
            if (rd_en)
            begin
                rd_q_reg[b]    <= bank_mem[b][rd_addr[b]];
                rd_addr_reg[b] <= rd_addr[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= '0;
        end
        else
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                if (wr[b].en)
                begin
                    fwd_valid_reg[b] <= 1'b1;
                end
            end
        end
    end

    // the latest write to a bank wins over the array copy read in the same edge
    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (fwd_valid_reg[b] && (fwd_addr_reg[b] == rd_addr_reg[b]))
            begin
                rd_data[b] = fwd_data_reg[b];
            end
            else
            begin
                rd_data[b] = rd_q_reg[b];
            end
        end
    end

endmodule
